// ===== hw/rtl/e2utc_pkg.sv =====
// Shared types, constants and helper functions for the epoch-seconds to
// UTC calendar converter. No dependencies; compiled first.
package e2utc_pkg;

  // Default width of the seconds input
  localparam int SECONDS_WIDTH_DEFAULT = 34;

  // Fixed spans in seconds for the day, hour and minute walks
  localparam int REM_WIDTH = 17;
  localparam logic [REM_WIDTH-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_WIDTH-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_WIDTH-1:0] SECS_PER_MIN  = 17'd60;

  // Year lengths in seconds
  localparam int YSEC_WIDTH = 25;
  localparam logic [YSEC_WIDTH-1:0] YEAR_SECS      = 25'd31536000;
  localparam logic [YSEC_WIDTH-1:0] LEAP_YEAR_SECS = 25'd31622400;

  // Month lengths in seconds
  localparam int MSEC_WIDTH = 22;
  localparam logic [MSEC_WIDTH-1:0] FEB_SECS      = 22'd2419200;
  localparam logic [MSEC_WIDTH-1:0] FEB_LEAP_SECS = 22'd2505600;
  localparam logic [MSEC_WIDTH-1:0] MONTH_30_SECS = 22'd2592000;
  localparam logic [MSEC_WIDTH-1:0] MONTH_31_SECS = 22'd2678400;

  // Day-in-year values: 0 .. 365
  localparam int DOY_WIDTH = 9;

  // Epoch year 1970 as an offset from 1900 and its place in the 400-year cycle
  localparam int YEAR_OUT_WIDTH = 10;
  localparam int Y400_WIDTH = 9;
  localparam logic [Y400_WIDTH-1:0] EPOCH_YEAR_OFS = 9'd70;
  localparam logic [Y400_WIDTH-1:0] EPOCH_Y400     = 9'd370;
  localparam logic [Y400_WIDTH-1:0] Y400_LAST      = 9'd399;
  localparam logic [Y400_WIDTH-1:0] CENTURY_1      = 9'd100;
  localparam logic [Y400_WIDTH-1:0] CENTURY_2      = 9'd200;
  localparam logic [Y400_WIDTH-1:0] CENTURY_3      = 9'd300;

  // Weekday: 1970-01-01 was a Thursday
  localparam logic [2:0] EPOCH_WDAY    = 3'd4;
  localparam logic [3:0] DAYS_PER_WEEK = 4'd7;
  // Shortest month; its length shifts the weekday by zero
  localparam logic [4:0] MONTH_MIN_DAYS = 5'd28;

  // Month codes with other than 31 days
  localparam logic [3:0] MON_FEB = 4'd1;
  localparam logic [3:0] MON_APR = 4'd3;
  localparam logic [3:0] MON_JUN = 4'd5;
  localparam logic [3:0] MON_SEP = 4'd8;
  localparam logic [3:0] MON_NOV = 4'd10;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic year_step;
    logic mon_step;
    logic day_step;
    logic hour_step;
    logic min_step;
    logic out_load;
  } e2utc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic year_done;
    logic mon_done;
    logic day_done;
    logic hour_done;
    logic min_done;
  } e2utc_sts_t;

  // Gregorian leap rule from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [Y400_WIDTH-1:0] y400);
    return (y400[1:0] == 2'd0) && (y400 != CENTURY_1) &&
           (y400 != CENTURY_2) && (y400 != CENTURY_3);
  endfunction

  // Length of a month in days
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    unique case (mon) inside
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

  // Length of a month in seconds
  function automatic logic [MSEC_WIDTH-1:0] month_secs(input logic [3:0] mon,
                                                       input logic leap);
    logic [MSEC_WIDTH-1:0] secs;
    unique case (mon) inside
      MON_FEB:                            secs = leap ? FEB_LEAP_SECS : FEB_SECS;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: secs = MONTH_30_SECS;
      default:                            secs = MONTH_31_SECS;
    endcase
    return secs;
  endfunction

endpackage

// ===== hw/rtl/e2utc_in_if.sv =====
// Input channel: valid/ready handshake carrying the seconds count.
// Depends on e2utc_pkg for the default width.
interface e2utc_in_if #(
  parameter int SECONDS_WIDTH = e2utc_pkg::SECONDS_WIDTH_DEFAULT
);
  logic                     valid;
  logic                     ready;
  logic [SECONDS_WIDTH-1:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

// ===== hw/rtl/e2utc_out_if.sv =====
// Output channel: valid/ready handshake carrying the broken-down UTC time.
// No dependencies.
interface e2utc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] second_of_minute;
  logic [5:0] minute_of_hour;
  logic [4:0] hour_of_day;
  logic [4:0] day_of_month;
  logic [3:0] month_index;
  logic [9:0] year_since_1900;
  logic [2:0] weekday;
  logic [8:0] day_of_year;

  modport source (output valid, output second_of_minute, output minute_of_hour,
                  output hour_of_day, output day_of_month, output month_index,
                  output year_since_1900, output weekday, output day_of_year,
                  input ready);
  modport sink   (input valid, input second_of_minute, input minute_of_hour,
                  input hour_of_day, input day_of_month, input month_index,
                  input year_since_1900, input weekday, input day_of_year,
                  output ready);
endinterface

// ===== hw/rtl/e2utc_dpath.sv =====
// Datapath of the calendar converter: year, month, day, hour and minute walks
// by subtracting seconds, weekday and day-of-year tracking, output register.
// Uses e2utc_pkg.
module e2utc_dpath #(
  parameter int SECONDS_WIDTH = e2utc_pkg::SECONDS_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic [SECONDS_WIDTH-1:0] seconds_since_epoch,
  input  e2utc_pkg::e2utc_cmd_t    cmd,
  output e2utc_pkg::e2utc_sts_t    sts,
  output logic [5:0]               second_of_minute,
  output logic [5:0]               minute_of_hour,
  output logic [4:0]               hour_of_day,
  output logic [4:0]               day_of_month,
  output logic [3:0]               month_index,
  output logic [9:0]               year_since_1900,
  output logic [2:0]               weekday,
  output logic [8:0]               day_of_year
);

  // Years after 1900 stay below 2**(SECONDS_WIDTH-22)
  localparam int YEAR_WIDTH = SECONDS_WIDTH - 22;
  localparam int DW = e2utc_pkg::DOY_WIDTH;

  // Working registers
  logic [SECONDS_WIDTH-1:0]         secs;   // seconds not yet walked off
  logic [YEAR_WIDTH-1:0]            year;   // year minus 1900
  logic [e2utc_pkg::Y400_WIDTH-1:0] y400;   // year mod 400
  logic [3:0]                       mon;
  logic [4:0]                       mday;   // whole days into the month
  logic [DW-1:0]                    doy;
  logic [2:0]                       wday;
  logic [4:0]                       hour;
  logic [5:0]                       minute;

  // Step lengths
  logic                                leap;
  logic [e2utc_pkg::YSEC_WIDTH-1:0]    ysecs;
  logic [4:0]                          mlen;
  logic [e2utc_pkg::MSEC_WIDTH-1:0]    msecs;

  // Weekday advance
  logic [1:0]    wday_inc;
  logic [3:0]    wsum;
  logic [2:0]    wday_next;

  always_comb begin
    leap  = e2utc_pkg::is_leap(y400);
    ysecs = leap ? e2utc_pkg::LEAP_YEAR_SECS : e2utc_pkg::YEAR_SECS;
    mlen  = e2utc_pkg::month_len(mon, leap);
    msecs = e2utc_pkg::month_secs(mon, leap);
    // a year moves the weekday by its length mod 7, a month by its length - 28
    if (cmd.year_step) begin
      wday_inc = {1'b0, leap} + 2'd1;
    end else if (cmd.mon_step) begin
      wday_inc = 2'(mlen - e2utc_pkg::MONTH_MIN_DAYS);
    end else begin
      wday_inc = 2'd1;
    end
    wsum      = {1'b0, wday} + {2'b00, wday_inc};
    wday_next = (wsum >= e2utc_pkg::DAYS_PER_WEEK) ? 3'(wsum - e2utc_pkg::DAYS_PER_WEEK)
                                                   : wsum[2:0];
  end

  // Status back to the controller
  always_comb begin
    sts.year_done = (secs < SECONDS_WIDTH'(ysecs));
    sts.mon_done  = (secs < SECONDS_WIDTH'(msecs));
    sts.day_done  = (secs < SECONDS_WIDTH'(e2utc_pkg::SECS_PER_DAY));
    sts.hour_done = (secs < SECONDS_WIDTH'(e2utc_pkg::SECS_PER_HOUR));
    sts.min_done  = (secs < SECONDS_WIDTH'(e2utc_pkg::SECS_PER_MIN));
  end

  // Advance the working registers on command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      secs   <= seconds_since_epoch;
      year   <= YEAR_WIDTH'(e2utc_pkg::EPOCH_YEAR_OFS);
      y400   <= e2utc_pkg::EPOCH_Y400;
      mon    <= '0;
      mday   <= '0;
      doy    <= '0;
      wday   <= e2utc_pkg::EPOCH_WDAY;
      hour   <= '0;
      minute <= '0;
    end else if (cmd.year_step) begin
      secs <= secs - SECONDS_WIDTH'(ysecs);
      year <= year + YEAR_WIDTH'(1);
      y400 <= (y400 == e2utc_pkg::Y400_LAST) ? '0 : y400 + e2utc_pkg::Y400_WIDTH'(1);
      wday <= wday_next;
    end else if (cmd.mon_step) begin
      secs <= secs - SECONDS_WIDTH'(msecs);
      mon  <= mon + 4'd1;
      doy  <= doy + DW'(mlen);
      wday <= wday_next;
    end else if (cmd.day_step) begin
      secs <= secs - SECONDS_WIDTH'(e2utc_pkg::SECS_PER_DAY);
      mday <= mday + 5'd1;
      doy  <= doy + DW'(1);
      wday <= wday_next;
    end else if (cmd.hour_step) begin
      secs <= secs - SECONDS_WIDTH'(e2utc_pkg::SECS_PER_HOUR);
      hour <= hour + 5'd1;
    end else if (cmd.min_step) begin
      secs   <= secs - SECONDS_WIDTH'(e2utc_pkg::SECS_PER_MIN);
      minute <= minute + 6'd1;
    end
  end

  // Capture the finished result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      second_of_minute <= secs[5:0];
      minute_of_hour   <= minute;
      hour_of_day      <= hour;
      day_of_month     <= mday + 5'd1;
      month_index      <= mon;
      year_since_1900  <= year[e2utc_pkg::YEAR_OUT_WIDTH-1:0];
      weekday          <= wday;
      day_of_year      <= doy;
    end
  end

endmodule

// ===== hw/rtl/e2utc_ctrl.sv =====
// Controller of the calendar converter: sequences the datapath phases and
// owns the handshakes. Uses e2utc_pkg command and status types.
module e2utc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  e2utc_pkg::e2utc_sts_t sts,
  output e2utc_pkg::e2utc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_YEAR;
      end
      S_YEAR: begin
        cmd.year_step = !sts.year_done;
        if (sts.year_done) state_next = S_MONTH;
      end
      S_MONTH: begin
        cmd.mon_step = !sts.mon_done;
        if (sts.mon_done) state_next = S_DAY;
      end
      S_DAY: begin
        cmd.day_step = !sts.day_done;
        if (sts.day_done) state_next = S_HOUR;
      end
      S_HOUR: begin
        cmd.hour_step = !sts.hour_done;
        if (sts.hour_done) state_next = S_MIN;
      end
      S_MIN: begin
        cmd.min_step = !sts.min_done;
        if (sts.min_done) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = !out_valid || out_ready;
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/epoch_seconds_to_utc_calendar_core.sv =====
// Converts by walking off, one step at a time, whole years since 1970, then months,
// whole days of the month, hours and minutes, with a phase change between walks;
// the year walk dominates the run time at the default width.
// One transaction is in work at a time; a finished result waits in the output
// register while the next is taken.
// Reset (rst, synchronous) returns the controller to idle, no output valid.
module epoch_seconds_to_utc_calendar_core #(
  parameter int SECONDS_WIDTH = e2utc_pkg::SECONDS_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  e2utc_in_if.sink     in_ch,
  e2utc_out_if.source  out_ch
);

  e2utc_pkg::e2utc_cmd_t cmd;
  e2utc_pkg::e2utc_sts_t sts;

  // Sequence the phases
  e2utc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Do the arithmetic
  e2utc_dpath #(
    .SECONDS_WIDTH (SECONDS_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .seconds_since_epoch (in_ch.seconds_since_epoch),
    .cmd                 (cmd),
    .sts                 (sts),
    .second_of_minute    (out_ch.second_of_minute),
    .minute_of_hour      (out_ch.minute_of_hour),
    .hour_of_day         (out_ch.hour_of_day),
    .day_of_month        (out_ch.day_of_month),
    .month_index         (out_ch.month_index),
    .year_since_1900     (out_ch.year_since_1900),
    .weekday             (out_ch.weekday),
    .day_of_year         (out_ch.day_of_year)
  );

endmodule

// ===== hw/rtl/e2utc_checker.sv =====
// Port-level checks for the calendar converter, bound to the top level.
// Depends on the top level and its channel interfaces.
module e2utc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] second_of_minute,
  input logic [5:0] minute_of_hour,
  input logic [4:0] hour_of_day,
  input logic [4:0] day_of_month,
  input logic [3:0] month_index,
  input logic [2:0] weekday
);

  // One transaction in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in work");

  // A new result follows a cycle with the input side closed
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // Delivered fields stay in their calendar ranges
  a_field_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second_of_minute < 6'd60) && (minute_of_hour < 6'd60) &&
                  (hour_of_day < 5'd24) && (day_of_month != 5'd0) &&
                  (month_index < 4'd12) && (weekday < 3'd7))
    else $error("result field out of range");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(second_of_minute) &&
                                $stable(day_of_month) && $stable(month_index))
    else $error("stalled result changed");

endmodule

bind epoch_seconds_to_utc_calendar_core e2utc_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .second_of_minute (out_ch.second_of_minute),
  .minute_of_hour   (out_ch.minute_of_hour),
  .hour_of_day      (out_ch.hour_of_day),
  .day_of_month     (out_ch.day_of_month),
  .month_index      (out_ch.month_index),
  .weekday          (out_ch.weekday)
);

// ===== verif/utc_calendar_tb_pkg.sv =====
`timescale 1ns / 100ps
// Expected-value side of the epoch-seconds to UTC calendar testbench:
// calendar record type, date helpers and the scoreboard class. No RTL dependencies.
package utc_calendar_tb_pkg;

  localparam int     SECS_WIDTH  = 34;
  localparam int     DAY_SECS    = 86400;
  localparam int     HOUR_SECS   = 3600;
  localparam int     MIN_SECS    = 60;
  localparam int     FIRST_YEAR  = 1970;
  localparam int     YEAR_ORIGIN = 1900;
  localparam int     THURSDAY    = 4;
  localparam int     WEEK_DAYS   = 7;
  localparam int     FEBRUARY    = 1;
  localparam int     MONTHS      = 12;
  localparam int     MONTH_DAYS [MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int     REPORT_LIMIT = 10;

  typedef logic [SECS_WIDTH-1:0] epoch_secs_t;

  typedef struct packed {
    logic [9:0] year;
    logic [3:0] month;
    logic [4:0] mday;
    logic [8:0] yday;
    logic [2:0] wday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } utc_calendar_t;

  typedef struct {
    epoch_secs_t   secs;
    utc_calendar_t cal;
  } pending_conv_t;

  // Gregorian rule on the full calendar year
  function automatic bit leap_year(input int yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  // Seconds since the epoch at a given year, day of year and second of day
  function automatic longint secs_at(input int yr, input int yday, input int sod);
    longint days;
    days = yday;
    for (int y = FIRST_YEAR; y < yr; y++) days += 365 + leap_year(y);
    return days * DAY_SECS + sod;
  endfunction

  function automatic string cal_str(input utc_calendar_t c);
    return $sformatf("year+1900=%0d mon=%0d mday=%0d yday=%0d wday=%0d %0d:%0d:%0d",
                     c.year, c.month, c.mday, c.yday, c.wday, c.hour, c.minute, c.second);
  endfunction

  class utc_calendar_scoreboard;
    pending_conv_t pending_q[$];
    int unsigned   converted;
    int unsigned   failures;

    // Break an accepted second count into its calendar fields and queue them
    function void note_seconds(input epoch_secs_t secs);
      pending_conv_t p;
      longint unsigned days, rem, ylen, mlen;
      int yr, mon;
      p.secs = secs;
      days = secs / DAY_SECS;
      rem  = secs % DAY_SECS;
      p.cal.hour   = 5'(rem / HOUR_SECS);
      rem          = rem % HOUR_SECS;
      p.cal.minute = 6'(rem / MIN_SECS);
      p.cal.second = 6'(rem % MIN_SECS);
      p.cal.wday   = 3'((days + THURSDAY) % WEEK_DAYS);
      // walk whole years from the epoch
      yr = FIRST_YEAR;
      forever begin
        ylen = 365 + leap_year(yr);
        if (days < ylen) break;
        days -= ylen;
        yr++;
      end
      p.cal.year = 10'(yr - YEAR_ORIGIN);
      p.cal.yday = 9'(days);
      // walk months, February stretched in leap years
      for (mon = 0; mon < MONTHS; mon++) begin
        mlen = MONTH_DAYS[mon];
        if (mon == FEBRUARY && leap_year(yr)) mlen = 29;
        if (days < mlen) break;
        days -= mlen;
      end
      p.cal.month = 4'(mon);
      p.cal.mday  = 5'(days + 1);
      pending_q.push_back(p);
    endfunction

    // Compare a result transaction with the oldest expectation
    function void check_calendar(input utc_calendar_t got);
      pending_conv_t p;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%t ERROR unexpected result: %s", $realtime, cal_str(got));
        return;
      end
      p = pending_q.pop_front();
      converted++;
      if (got !== p.cal) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%t ERROR mismatch for seconds %0d", $realtime, p.secs);
          $display("  expected %s", cal_str(p.cal));
          $display("  actual   %s", cal_str(got));
        end
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the epoch-seconds to UTC calendar testbench: clock, reset, drivers and monitor.
// Depends on e2utc_pkg, both channel interfaces, the core and utc_calendar_tb_pkg.
module tb_top;
  import utc_calendar_tb_pkg::*;

  localparam int     HOLD_CYCLES      = 3000;
  localparam int     TAIL_CYCLES      = 700;
  localparam int     RANDOM_PER_PHASE = 163;
  localparam int     PHASES           = 4;
  localparam int     IDLE_PCT  [PHASES] = '{0, 69, 0, 29};
  localparam int     STALL_PCT [PHASES] = '{0, 0, 69, 29};
  localparam longint SECS_MAX = (longint'(1) << SECS_WIDTH) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct;
  int   stall_pct;
  int   hold_requests;
  utc_calendar_scoreboard sb;

  e2utc_in_if #(.SECONDS_WIDTH(SECS_WIDTH)) in_ch ();
  e2utc_out_if out_ch ();

  epoch_seconds_to_utc_calendar_core #(.SECONDS_WIDTH(SECS_WIDTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels; note accepted inputs, check accepted results
  always @(posedge clk) begin
    utc_calendar_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_seconds(in_ch.seconds_since_epoch);
      if (out_ch.valid && out_ch.ready) begin
        got.year   = out_ch.year_since_1900;
        got.month  = out_ch.month_index;
        got.mday   = out_ch.day_of_month;
        got.yday   = out_ch.day_of_year;
        got.wday   = out_ch.weekday;
        got.hour   = out_ch.hour_of_day;
        got.minute = out_ch.minute_of_hour;
        got.second = out_ch.second_of_minute;
        sb.check_calendar(got);
      end
    end
  end

  // Drive result ready: random stalls, or a long hold-off when requested
  initial begin
    int served;
    served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one transaction after random idle cycles and hold it until accepted
  task automatic send_seconds(input epoch_secs_t secs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.seconds_since_epoch <= epoch_secs_t'({$urandom_range(3), $urandom});
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.seconds_since_epoch <= secs;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Mix of full-range counts, 32-bit counts, year edges and leap-day edges
  function automatic epoch_secs_t random_seconds();
    longint s;
    int yr, yday, sod;
    case ($urandom_range(9))
      0, 1, 2, 3: s = longint'({$urandom_range(3), $urandom});
      4, 5:       s = longint'($urandom);
      6, 7: begin
        yr = FIRST_YEAR + $urandom_range(544);
        s  = secs_at(yr, 0, 0) + longint'($urandom_range(4 * DAY_SECS)) - 2 * DAY_SECS;
      end
      default: begin
        case ($urandom_range(6))
          0:       yr = 2000;
          1:       yr = 2100;
          2:       yr = 2200;
          3:       yr = 2300;
          4:       yr = 2400;
          5:       yr = 2500;
          default: yr = 1972 + 4 * $urandom_range(135);
        endcase
        case ($urandom_range(3))
          0:       yday = 58;
          1:       yday = 59;
          2:       yday = 60;
          default: yday = 364 + leap_year(yr);
        endcase
        case ($urandom_range(2))
          0:       sod = 0;
          1:       sod = DAY_SECS - 1;
          default: sod = $urandom_range(DAY_SECS - 1);
        endcase
        s = secs_at(yr, yday, sod);
      end
    endcase
    if (s < 0) s = 0;
    if (s > SECS_MAX) s = SECS_MAX;
    return epoch_secs_t'(s);
  endfunction

  initial begin
    epoch_secs_t directed_q[$];
    sb = new();
    in_ch.valid = 1'b0;
    in_ch.seconds_since_epoch = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: epoch, day and year edges, leap and century rules, bit patterns
    directed_q.push_back('0);
    directed_q.push_back(epoch_secs_t'(DAY_SECS - 1));
    directed_q.push_back(epoch_secs_t'(DAY_SECS));
    directed_q.push_back(epoch_secs_t'(secs_at(1970, 364, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(1971, 0, 0)));
    directed_q.push_back(epoch_secs_t'(secs_at(1972, 58, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(1972, 59, 43200)));
    directed_q.push_back(epoch_secs_t'(secs_at(1972, 60, 0)));
    directed_q.push_back(epoch_secs_t'(secs_at(1972, 365, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(2000, 59, HOUR_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(2000, 365, 0)));
    directed_q.push_back(epoch_secs_t'(secs_at(2100, 58, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(2100, 59, 0)));
    directed_q.push_back(epoch_secs_t'(secs_at(2100, 364, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(2400, 59, MIN_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(secs_at(2500, 364, DAY_SECS - 1)));
    directed_q.push_back(epoch_secs_t'(64'h7FFF_FFFF));
    directed_q.push_back(epoch_secs_t'(64'hFFFF_FFFF));
    directed_q.push_back(epoch_secs_t'(64'h1_0000_0000));
    directed_q.push_back(34'h2_AAAA_AAAA);
    directed_q.push_back(34'h1_5555_5555);
    directed_q.push_back(epoch_secs_t'(SECS_MAX));
    foreach (directed_q[i]) send_seconds(directed_q[i]);
    wait_drained();

    // Random phases; the first opens with a long output hold-off under full input load
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      if (ph == 0) hold_requests++;
      repeat (RANDOM_PER_PHASE) send_seconds(random_seconds());
      wait_drained();
    end

    // Watch for stray results after the last expected one
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d conversions: directed epoch, leap-day, century and year-end cases,",
             sb.converted);
    $display("then %0d random counts over four handshake mixes and a %0d-cycle output hold-off.",
             PHASES * RANDOM_PER_PHASE, HOLD_CYCLES);
    if (sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", sb.failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
